FILE: hdl/crc64_combine_gf_multiply_defines.svh
// ---------------------------------------------------------------------------
// crc64_combine_gf_multiply assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef CRC64_COMBINE_GF_MULTIPLY_DEFINES_SVH
`define CRC64_COMBINE_GF_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS
`define CRC64C_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRC64C_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRC64C_ASSERT(name, clk, rst_n, prop, msg)
`define CRC64C_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/crc64c_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc64c_pkg
// Shared constants, types and GF(2^64) helpers for the CRC-64 combine block.
// ---------------------------------------------------------------------------
package crc64c_pkg;

  localparam logic [63:0] CRC64_POLY = 64'hC96C5795D7870F42;
  localparam int CRC_W           = 64;
  localparam int MAX_LENGTH_BITS = 63;
  localparam int TAB_IDX_W       = 6;
  localparam int DIGIT_BITS      = 8;
  localparam int DIGITS          = CRC_W / DIGIT_BITS;
  localparam int DIG_W           = $clog2(DIGITS);

  typedef logic [MAX_LENGTH_BITS-1:0][CRC_W-1:0] pow_tab_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic advance;
    logic mul_start;
    logic mul_step;
    logic mul_commit;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_bit;
    logic dig_last;
    logic out_free;
  } dp_status_t;

  // multiply by x, reflected order (bit 63 is x^0)
  function automatic logic [CRC_W-1:0] gf_times_x(logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    r = v >> 1;
    if (v[0]) r = r ^ CRC64_POLY;
    return r;
  endfunction

  // full product, only evaluated at elaboration to build the power table
  function automatic logic [CRC_W-1:0] gf_product(logic [CRC_W-1:0] a,
                                                   logic [CRC_W-1:0] b);
    logic [CRC_W-1:0] acc;
    logic [CRC_W-1:0] bb;
    acc = '0;
    bb  = b;
    for (int i = 0; i < CRC_W; i++) begin
      acc = gf_times_x(acc);
      if (bb[0]) acc = acc ^ a;
      bb = bb >> 1;
    end
    return acc;
  endfunction

  // entry k holds x^(8*2^k) mod P
  function automatic pow_tab_t build_power_table();
    pow_tab_t         t;
    logic [CRC_W-1:0] v;
    v = gf_times_x(64'h0100_0000_0000_0000);
    for (int k = 0; k < MAX_LENGTH_BITS; k++) begin
      t[k] = v;
      v    = gf_product(v, v);
    end
    return t;
  endfunction

  localparam pow_tab_t POWER_TABLE = build_power_table();

endpackage

FILE: hdl/crc64c_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc64c_ctrl
// Sequencer: walks the length bits and runs one digit-serial multiply per
// set bit.
// ---------------------------------------------------------------------------
module crc64c_ctrl
  import crc64c_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dp_status_t  status_i,
  output ctrl_cmd_t   cmd_o,
  output ctrl_state_e state_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status_i.len_zero) begin
          // hold until the output register can take the word
          if (status_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (status_i.len_bit) begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_MUL;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.dig_last) begin
          cmd_o.mul_commit = 1'b1;
          cmd_o.advance    = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

FILE: hdl/crc64c_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc64c_datapath
// Operand registers, 8-bit-per-cycle GF(2^64) multiplier and output register.
// ---------------------------------------------------------------------------
module crc64c_datapath
  import crc64c_pkg::*;
#(
  parameter int LENGTH_BITS = 63
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  input  logic [CRC_W-1:0]       crc_first_i,
  input  logic [CRC_W-1:0]       crc_second_i,
  input  logic [LENGTH_BITS-1:0] length_second_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CRC_W-1:0]       crc_combined_o
);

  localparam int KW = (LENGTH_BITS > 1) ? $clog2(LENGTH_BITS) : 1;

  logic [CRC_W-1:0]       crc_q;
  logic [CRC_W-1:0]       second_q;
  logic [LENGTH_BITS-1:0] len_q;
  logic [KW-1:0]          k_q;
  logic                   nz_q;
  logic [CRC_W-1:0]       acc_q;
  logic [CRC_W-1:0]       acc_d;
  logic [CRC_W-1:0]       b_q;
  logic [DIG_W-1:0]       dig_q;
  logic                   out_valid_q;
  logic [CRC_W-1:0]       out_q;

  // one digit of the product: eight shift-and-add steps, b taken lsb first
  always_comb begin
    acc_d = acc_q;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      acc_d = gf_times_x(acc_d);
      if (b_q[i]) acc_d = acc_d ^ crc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      crc_q    <= crc_first_i;
      second_q <= crc_second_i;
      len_q    <= length_second_i;
      k_q      <= '0;
      nz_q     <= |length_second_i;
    end
    if (cmd_i.advance) begin
      len_q <= len_q >> 1;
      k_q   <= k_q + 1'b1;
    end
    if (cmd_i.mul_start) begin
      acc_q <= '0;
      b_q   <= POWER_TABLE[TAB_IDX_W'(k_q)];
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_d;
      b_q   <= b_q >> DIGIT_BITS;
    end
    if (cmd_i.mul_commit) begin
      crc_q <= acc_d;
    end
    if (cmd_i.finish) begin
      out_q <= nz_q ? (crc_q ^ second_q) : crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mul_start) begin
        dig_q <= '0;
      end else if (cmd_i.mul_step) begin
        dig_q <= dig_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.len_zero = (len_q == '0);
  assign status_o.len_bit  = len_q[0];
  assign status_o.dig_last = (dig_q == DIG_W'(DIGITS - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign crc_combined_o = out_q;

endmodule

FILE: hdl/crc64_combine_gf_multiply.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crc64_combine_gf_multiply
// CRC-64 combine: first * x^(8*len) mod P xor second (len > 0), reflected order.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes a word of crc_first_i,
// crc_second_i and length_second_i; output channel (out_valid_o/out_ready_i)
// returns one crc_combined_o word per input word.
// The sequencer works on one word at a time. After acceptance it steps
// once over each clear length bit below the highest set bit; on each set
// bit it loads the power constant, then runs the product through the
// shared multiplier eight bits at a time; last it loads the output
// register. A zero length returns crc_first_i without the xor. in_ready_o
// is high again in the cycle out_valid_o rises.
// The power constants are fixed logic, so reset only clears the sequencer,
// the digit counter and the output valid flag; no preload is needed.
// A stalled receiver holds the result in the output register; the next
// word may be accepted meanwhile and waits at its final step until the
// register is free.
// ---------------------------------------------------------------------------
`include "crc64_combine_gf_multiply_defines.svh"

module crc64_combine_gf_multiply
  import crc64c_pkg::*;
#(
  parameter int LENGTH_BITS = 63
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CRC_W-1:0]       crc_first_i,
  input  logic [CRC_W-1:0]       crc_second_i,
  input  logic [LENGTH_BITS-1:0] length_second_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CRC_W-1:0]       crc_combined_o
);

  ctrl_cmd_t   cmd;
  dp_status_t  status;
  ctrl_state_e state;

  crc64c_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  crc64c_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .crc_first_i     (crc_first_i),
    .crc_second_i    (crc_second_i),
    .length_second_i (length_second_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .crc_combined_o  (crc_combined_o)
  );

  // a multiply only runs on a set length bit, which stays put until it ends
  `CRC64C_ASSERT(a_mul_on_set_bit, clk_i, rst_ni, (state == ST_MUL) |-> status.len_bit, "multiply running without a set length bit")
  // result never overwrites an unsent word
  `CRC64C_ASSERT(a_finish_slot_free, clk_i, rst_ni, cmd.finish |-> (!out_valid_o || out_ready_i), "output word overwritten")
  // digit counter is back at zero whenever the sequencer scans
  `CRC64C_ASSERT(a_scan_digit_clear, clk_i, rst_ni, (state == ST_SCAN) |-> !status.dig_last, "digit counter not cleared between multiplies")
  `CRC64C_ASSERT_NEXT(a_accept_to_scan, clk_i, rst_ni, in_valid_i && in_ready_o, state == ST_SCAN, "accepted word not scanned")

endmodule
